// ===== rtl/core/lcs_pkg.sv =====
package lcs_pkg;

    localparam int MAX_LEN = 128;
    localparam int SYM_W   = 8;
    localparam int LEN_W   = 8;
    // Row entries hold 0..MAX_LEN, counts hold 0..MAX_LEN
    localparam int ROW_W   = $clog2(MAX_LEN + 1);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_COMPARE = 2'd1,
        ACT_END     = 2'd2
    } action_t;

    // One streamed symbol on its way down the cell row
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
        logic [ROW_W-1:0] diag;
        logic [ROW_W-1:0] left;
    } wave_t;

endpackage

// ===== rtl/core/lcs_req_if.sv =====
interface lcs_req_if import lcs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       action;
    logic [SYM_W-1:0] symbol;

    modport source (output valid, output action, output symbol, input ready);
    modport sink   (input valid, input action, input symbol, output ready);
endinterface

// ===== rtl/core/lcs_rsp_if.sv =====
interface lcs_rsp_if import lcs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] match_len;
    logic             overflowed;

    modport source (output valid, output match_len, output overflowed, input ready);
    modport sink   (input valid, input match_len, input overflowed, output ready);
endinterface

// ===== rtl/core/lcs_cell.sv =====
module lcs_cell import lcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             load_en,
    input  logic [SYM_W-1:0] load_symbol,
    input  wave_t            wave_in,
    output wave_t            wave_out,
    output logic [ROW_W-1:0] row
);

    logic             valid_reg, valid_next;
    logic [SYM_W-1:0] symbol_reg, symbol_next;
    logic [ROW_W-1:0] row_reg, row_next;
    wave_t            wave_reg, wave_next;
    logic [ROW_W-1:0] cell_val;

    // An unloaded cell mirrors its left neighbor, so the last cell always
    // carries the entry of the last loaded column.
    always_comb
    begin
        if (!valid_reg)
            cell_val = wave_in.left;
        else if (symbol_reg == wave_in.symbol)
            cell_val = wave_in.diag + ROW_W'(1);
        else if (row_reg > wave_in.left)
            cell_val = row_reg;
        else
            cell_val = wave_in.left;
    end

    always_comb
    begin
        valid_next  = valid_reg;
        symbol_next = symbol_reg;
        row_next    = row_reg;
        wave_next   = wave_in;
        wave_next.diag = row_reg;
        wave_next.left = cell_val;
        if (clear)
        begin
            valid_next = 1'b0;
            row_next   = '0;
        end
        else if (load_en)
        begin
            valid_next  = 1'b1;
            symbol_next = load_symbol;
        end
        else if (wave_in.valid)
        begin
            row_next = cell_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            row_reg   <= '0;
            wave_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            row_reg   <= row_next;
            wave_reg  <= wave_next;
        end
    end

    always_ff @(posedge clk)
    begin
        symbol_reg <= symbol_next;
    end

    assign wave_out = wave_reg;
    assign row      = row_reg;

endmodule

// ===== rtl/core/lcs_length_core.sv =====
// Channel | Dir | Payload                         | Transaction
// req     | in  | action[1:0], symbol[7:0]        | load, compare, end of pair
// rsp     | out | match_len[7:0], overflowed      | one per end of pair
//
// A compare can be taken every cycle; cell i takes its update once the compare
// has passed through inject_reg and the wave registers of cells 0..i-1 in turn.
// Load and end hold until the row has drained: the earliest is accepted once the
// drain count set by the last compare is zero, back to back when none is in flight.
// End also waits for a free result register; its result is valid the next cycle.
// Reset (rst_n, asynchronous) empties the reference and zeroes the row at once.
// A stalled rsp holds its result and still lets compares and loads through.
module lcs_length_core import lcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    lcs_req_if.sink  req,
    lcs_rsp_if.source rsp
);

    localparam int CMP_W = (ROW_W > LEN_W) ? ROW_W : LEN_W;

    logic             req_ready;
    logic             req_fire;
    action_t          act;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] drain_reg, drain_next;
    logic             ovf_reg, ovf_next;
    wave_t            inject_reg, inject_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             rsp_ovf_reg, rsp_ovf_next;

    logic             do_load;
    logic             do_end;
    logic             clear;
    logic [MAX_LEN-1:0] load_en;

    wave_t            wave [MAX_LEN+1];
    logic [ROW_W-1:0] row  [MAX_LEN];
    logic [ROW_W-1:0] last_row;
    logic [LEN_W-1:0] sat_len;

    assign act      = action_t'(req.action);
    assign req_fire = req.valid && req_ready;

    // Hold load and end until every wave has left the row.
    always_comb
    begin
        unique case (act)
            ACT_LOAD:    req_ready = (drain_reg == '0);
            ACT_END:     req_ready = (drain_reg == '0) && (!rsp_valid_reg || rsp.ready);
            ACT_COMPARE: req_ready = 1'b1;
            default:     req_ready = 1'b1;
        endcase
    end
    assign req.ready = req_ready;

    assign do_load = req_fire && (act == ACT_LOAD);
    assign do_end  = req_fire && (act == ACT_END);
    assign clear   = do_end;

    // Saturate the final entry to the output width.
    assign last_row = row[MAX_LEN-1];
    always_comb
    begin
        if (CMP_W'(last_row) > CMP_W'({LEN_W{1'b1}}))
            sat_len = {LEN_W{1'b1}};
        else
            sat_len = LEN_W'(last_row);
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        drain_next     = (drain_reg != '0) ? drain_reg - CNT_W'(1) : drain_reg;
        inject_next    = '0;
        rsp_valid_next = rsp_valid_reg;
        len_next       = len_reg;
        rsp_ovf_next   = rsp_ovf_reg;

        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        if (req_fire)
        begin
            unique case (act)
                ACT_LOAD:
                begin
                    // Drop the symbol and flag it once the row is full.
                    if (count_reg == CNT_W'(MAX_LEN))
                        ovf_next = 1'b1;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                ACT_COMPARE:
                begin
                    inject_next.valid  = 1'b1;
                    inject_next.symbol = req.symbol;
                    drain_next         = CNT_W'(MAX_LEN);
                end
                ACT_END:
                begin
                    rsp_valid_next = 1'b1;
                    len_next       = sat_len;
                    rsp_ovf_next   = ovf_reg;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                end
                default:
                begin
                    // Unused action: drop it.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drain_reg     <= '0;
            ovf_reg       <= 1'b0;
            inject_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            drain_reg     <= drain_next;
            ovf_reg       <= ovf_next;
            inject_reg    <= inject_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        rsp_ovf_reg <= rsp_ovf_next;
    end

    // Row of cells: each takes the wave from its left neighbor.
    assign wave[0] = inject_reg;

    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_cell
        assign load_en[i] = do_load && (count_reg == CNT_W'(i));

        lcs_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .clear       (clear),
            .load_en     (load_en[i]),
            .load_symbol (req.symbol),
            .wave_in     (wave[i]),
            .wave_out    (wave[i+1]),
            .row         (row[i])
        );
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.match_len  = len_reg;
    assign rsp.overflowed = rsp_ovf_reg;

    // A load never lands while a wave is still in the row.
    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        do_load |-> (drain_reg == '0))
        else $error("load accepted during drain");

    // An end transaction produces a result in the next cycle.
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        do_end |=> rsp_valid_reg)
        else $error("end without result");

    // Reference count stays within the row.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("reference count out of range");

    // After an end the row and reference are empty.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        do_end |=> (count_reg == '0) && !ovf_reg)
        else $error("end did not clear state");

endmodule
